@@ design/lsmx_pkg.sv @@
`default_nettype none
// ============================================================================
// lsmx_pkg
// Shared types and constants for the max-extract key table.
// ============================================================================
package lsmx_pkg;

    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 10;
    localparam int CNT_CFG_W       = 11;
    localparam int TABLE_DEPTH_DEF = 1024;

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CNT_CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    // Register word select (paddr bit above the byte offset)
    localparam logic REG_ENTRIES = 1'b0;

    // Request kinds carried on tuser
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic signed [KEY_W-1:0] REMOVED_KEY = -32'sd1;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;

    // Broadcast control seen by every cell
    typedef struct packed {
        logic                    load_en;
        logic [SLOT_W-1:0]       load_slot;
        logic signed [KEY_W-1:0] load_key;
        logic                    clear_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/lsmx_cell.sv @@
`default_nettype none
// ============================================================================
// lsmx_cell
// One table entry plus one stage of the best-key token that walks the chain.
// ============================================================================
module lsmx_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 10,
    parameter int CNT_W      = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lsmx_pkg::cell_ctrl_t           ctrl,
    input  wire logic [IDX_W-1:0]               clear_idx,
    input  wire logic [CNT_W-1:0]               count_eff,
    input  wire logic                           tok_valid_in,
    input  wire logic signed [lsmx_pkg::KEY_W-1:0] tok_key_in,
    input  wire logic [IDX_W-1:0]               tok_idx_in,
    output logic                                tok_valid_out,
    output logic signed [lsmx_pkg::KEY_W-1:0]   tok_key_out,
    output logic [IDX_W-1:0]                    tok_idx_out
);

    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(CELL_INDEX);
    localparam logic [31:0]      CELL_U32 = 32'(CELL_INDEX);

    logic signed [lsmx_pkg::KEY_W-1:0] key_reg;
    logic                              tok_valid_reg;
    logic signed [lsmx_pkg::KEY_W-1:0] tok_key_reg;
    logic [IDX_W-1:0]                  tok_idx_reg;

    logic in_range;
    logic take;
    logic load_hit;
    logic clear_hit;

    assign in_range  = (CELL_POS < count_eff);
    // strict compare keeps the lowest index on a tie
    assign take      = in_range && (key_reg > tok_key_in);
    assign load_hit  = ctrl.load_en && (32'(ctrl.load_slot) == CELL_U32);
    assign clear_hit = ctrl.clear_en && (clear_idx == CELL_IDX);

    always_ff @(posedge clk)
    begin
        if (clear_hit)
        begin
            key_reg <= lsmx_pkg::REMOVED_KEY;
        end
        else if (load_hit)
        begin
            key_reg <= ctrl.load_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    // Advance the token, replacing its best with this entry when it is in range and larger
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_key_reg <= key_reg;
            tok_idx_reg <= CELL_IDX;
        end
        else
        begin
            tok_key_reg <= tok_key_in;
            tok_idx_reg <= tok_idx_in;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_key_out   = tok_key_reg;
    assign tok_idx_out   = tok_idx_reg;

endmodule
`default_nettype wire

@@ design/linear_scan_max_extract_table_core.sv @@
`default_nettype none
// ============================================================================
// linear_scan_max_extract_table_core
// Key table with delete-max, scanned by a token passed along a row of cells.
// ============================================================================
// Load request: a new load may be taken every cycle while the core is idle.
// Delete-max request: the token crosses TABLE_DEPTH cells at one cell per cycle,
//   then the tail result is registered into the output register, and the next
//   request is taken once the core is back in idle; loads also wait for the
//   delete; a result still waiting in the output register stalls it further.
// Reset: control state clears, entries_in_use returns to 1024; keys stay
//   undefined until loaded.
module linear_scan_max_extract_table_core #(
    parameter int TABLE_DEPTH = lsmx_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB-style configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lsmx_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lsmx_pkg::DATA_W-1:0]   pwdata,
    output logic [lsmx_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [47:0]                   s_axis_tdata,  // slot_index[9:0], key_value[41:10]
    input  wire logic                          s_axis_tuser,  // mode[0]
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [47:0]                        m_axis_tdata   // max_key[31:0], max_index[41:32]
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W = lsmx_pkg::SLOT_W;
    localparam int KEY_W     = lsmx_pkg::KEY_W;
    localparam int CFG_W     = lsmx_pkg::CNT_CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        entries_reg;
    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [OUT_IDX_W-1:0]    out_idx_reg;
    logic signed [KEY_W-1:0] hold_key_reg;
    logic [OUT_IDX_W-1:0]    hold_idx_reg;

    logic                    cfg_wr;
    logic                    accept_in;
    logic                    start_delete;
    logic                    out_free;
    logic                    out_load;
    logic [31:0]             cnt_wide;
    logic [CNT_W-1:0]        count_eff;
    lsmx_pkg::cell_ctrl_t    ctrl;

    logic [TABLE_DEPTH-1:0]  tok_valid;
    logic signed [KEY_W-1:0] tok_key [TABLE_DEPTH];
    logic [IDX_W-1:0]        tok_idx [TABLE_DEPTH];

    logic                    tail_valid;
    logic signed [KEY_W-1:0] tail_key;
    logic [IDX_W-1:0]        tail_idx;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= lsmx_pkg::ENTRIES_RESET;
        end
        else if (cfg_wr && (paddr[lsmx_pkg::ADDR_W-1] == lsmx_pkg::REG_ENTRIES))
        begin
            entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[lsmx_pkg::ADDR_W-1])
            lsmx_pkg::REG_ENTRIES: prdata = lsmx_pkg::DATA_W'(entries_reg);
            default:               prdata = '0;
        endcase
    end

    // Clamp the scan length to 1 .. TABLE_DEPTH
    always_comb
    begin
        cnt_wide = 32'(entries_reg);
        if (cnt_wide == 32'd0)
        begin
            cnt_wide = 32'd1;
        end
        else if (cnt_wide > 32'(TABLE_DEPTH))
        begin
            cnt_wide = 32'(TABLE_DEPTH);
        end
        count_eff = CNT_W'(cnt_wide);
    end

    // ---------------- request side ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign start_delete  = accept_in && (s_axis_tuser == lsmx_pkg::MODE_DELETE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = out_free
                           && (((state_reg == ST_SCAN) && tail_valid) || (state_reg == ST_HOLD));

    assign tail_valid = tok_valid[TABLE_DEPTH-1];
    assign tail_key   = tok_key[TABLE_DEPTH-1];
    assign tail_idx   = tok_idx[TABLE_DEPTH-1];

    always_comb
    begin
        ctrl.load_en   = accept_in && (s_axis_tuser == lsmx_pkg::MODE_LOAD);
        ctrl.load_slot = s_axis_tdata[9:0];
        ctrl.load_key  = s_axis_tdata[41:10];
        // overwrite the winner with REMOVED_KEY as its token leaves the chain
        ctrl.clear_en  = tail_valid;
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic                    in_valid;
        logic signed [KEY_W-1:0] in_key;
        logic [IDX_W-1:0]        in_idx;

        if (g == 0)
        begin : g_head
            assign in_valid = start_delete;
            assign in_key   = lsmx_pkg::KEY_MIN;
            assign in_idx   = '0;
        end
        else
        begin : g_link
            assign in_valid = tok_valid[g-1];
            assign in_key   = tok_key[g-1];
            assign in_idx   = tok_idx[g-1];
        end

        lsmx_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .clear_idx     (tail_idx),
            .count_eff     (count_eff),
            .tok_valid_in  (in_valid),
            .tok_key_in    (in_key),
            .tok_idx_in    (in_idx),
            .tok_valid_out (tok_valid[g]),
            .tok_key_out   (tok_key[g]),
            .tok_idx_out   (tok_idx[g])
        );
    end

    // ---------------- control and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_key_reg   <= '0;
            out_idx_reg   <= '0;
            hold_key_reg  <= '0;
            hold_idx_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_delete)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (tail_valid)
                    begin
                        if (out_free)
                        begin
                            out_key_reg   <= tail_key;
                            out_idx_reg   <= OUT_IDX_W'(tail_idx);
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            hold_key_reg <= tail_key;
                            hold_idx_reg <= OUT_IDX_W'(tail_idx);
                            state_reg    <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_key_reg   <= hold_key_reg;
                        out_idx_reg   <= hold_idx_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_idx_reg, out_key_reg};

    // ---------------- assertions ----------------
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid))
        else $error("more than one token in the cell row");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> (state_reg == ST_SCAN))
        else $error("token left the row outside a scan");

    a_hold_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result held while output register is empty");

    a_start_token: assert property (@(posedge clk) disable iff (!rst_n)
        start_delete |=> (tok_valid[0] && (state_reg == ST_SCAN)))
        else $error("delete request did not launch a token");

endmodule
`default_nettype wire
